// File: design/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared constants for the tile key cache: default sizes and port field widths.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int CACHE_SIZE    = 16;
    localparam int KEY_BITS      = 32;

    localparam int TILE_KEY_BITS = 32;
    localparam int SLOT_BITS     = 4;
    localparam int EVKEY_BITS    = 32;

endpackage

// File: design/ltc_req_if.sv
// ----------------------------------------------------------------------------
// ltc_req_if
// Request channel of the tile key cache: one tile key per transfer.
// ----------------------------------------------------------------------------
interface ltc_req_if;

    logic                               valid;
    logic                               ready;
    logic [ltc_pkg::TILE_KEY_BITS-1:0]  tile_key;

    modport source (output valid, output tile_key, input ready);
    modport sink   (input valid, input tile_key, output ready);

endinterface

// File: design/ltc_rsp_if.sv
// ----------------------------------------------------------------------------
// ltc_rsp_if
// Response channel of the tile key cache: hit flag, slot and eviction report.
// ----------------------------------------------------------------------------
interface ltc_rsp_if;

    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [ltc_pkg::SLOT_BITS-1:0]      slot;
    logic                               evicted;
    logic [ltc_pkg::EVKEY_BITS-1:0]     evicted_key;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_key, output ready);

endinterface

// File: design/ltc_ram.sv
// ----------------------------------------------------------------------------
// ltc_ram
// Synchronous RAM with one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ltc_ram #(
    parameter int WIDTH = ltc_pkg::KEY_BITS,
    parameter int DEPTH = ltc_pkg::CACHE_SIZE
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: design/lru_tile_cache.sv
// ----------------------------------------------------------------------------
// lru_tile_cache
// Fully associative LRU tag store for tile keys. Keys and recency ranks live
// in two RAMs; each request is a scan pass followed by a rank update pass.
// ----------------------------------------------------------------------------
// a new request is accepted only in idle, once the previous result has moved to
// the output register; each request makes two sweeps over the single read port
// of each RAM, a scan and a rank update
// reset: valid bits and entry count clear at once, no clearing pass needed
module lru_tile_cache #(
    parameter int CACHE_SIZE = ltc_pkg::CACHE_SIZE,
    parameter int KEY_BITS   = ltc_pkg::KEY_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    ltc_req_if.sink  req,
    ltc_rsp_if.source rsp
);

    localparam int AW = $clog2(CACHE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_SIZE - 1);
    localparam logic [AW-1:0] FULL_CNT = AW'(CACHE_SIZE - 1);
    localparam logic [AW-1:0] OLD_RANK = AW'(CACHE_SIZE - 2);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_PLACE  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]         idx_reg;
    logic                  issue_done_reg;
    logic                  rd_pend_reg, rd_pend_next;
    logic [AW-1:0]         rd_idx_reg;

    logic [KEY_BITS-1:0]   key_reg;
    logic                  hit_reg;
    logic [AW-1:0]         hit_idx_reg;
    logic [AW-1:0]         hit_rank_reg;
    logic                  free_found_reg;
    logic [AW-1:0]         free_idx_reg;
    logic                  evict_reg;
    logic [AW-1:0]         victim_idx_reg;
    logic [KEY_BITS-1:0]   victim_key_reg;
    logic [AW-1:0]         slot_reg;

    logic [CACHE_SIZE-1:0] valid_reg, valid_next;
    logic [AW-1:0]         count_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg;
    logic [AW-1:0]         out_slot_reg;
    logic                  out_evicted_reg;
    logic [KEY_BITS-1:0]   out_evkey_reg;

    logic [KEY_BITS-1:0]   key_rd;
    logic [AW-1:0]         rank_rd;
    logic                  key_we;
    logic                  rank_we;
    logic [AW-1:0]         rank_wdata;

    logic                  accept;
    logic                  scan_data;
    logic                  upd_data;
    logic                  issue;
    logic                  finish_go;
    logic                  cur_valid;
    logic                  victim_here;

    ltc_ram #(.WIDTH(KEY_BITS), .DEPTH(CACHE_SIZE)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (key_rd)
    );

    ltc_ram #(.WIDTH(AW), .DEPTH(CACHE_SIZE)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rd_idx_reg),
        .wdata (rank_wdata),
        .raddr (idx_reg),
        .rdata (rank_rd)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign issue     = (state_reg == ST_SCAN || state_reg == ST_UPDATE) && !issue_done_reg;
    assign scan_data = (state_reg == ST_SCAN) && rd_pend_reg;
    assign upd_data  = (state_reg == ST_UPDATE) && rd_pend_reg;
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);
    assign cur_valid = valid_reg[rd_idx_reg];
    assign victim_here = evict_reg && (rd_idx_reg == victim_idx_reg);
    assign key_we    = finish_go && !hit_reg;

    // rank update for the entry whose data just came back
    always_comb
    begin
        rank_we    = 1'b0;
        rank_wdata = '0;
        if (upd_data)
        begin
            if (rd_idx_reg == slot_reg)
            begin
                rank_we = 1'b1;
            end
            else if (cur_valid && !victim_here && (!hit_reg || rank_rd < hit_rank_reg))
            begin
                rank_we    = 1'b1;
                rank_wdata = AW'(rank_rd + 1'b1);
            end
        end
    end

    // valid bits after a miss: victim freed, new entry taken
    always_comb
    begin
        valid_next = valid_reg;
        if (finish_go && !hit_reg)
        begin
            if (evict_reg)
            begin
                valid_next[victim_idx_reg] = 1'b0;
            end
            valid_next[slot_reg] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_pend_reg && rd_idx_reg == LAST_IDX)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (rd_pend_reg && rd_idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_pend_next   = issue;
    assign out_valid_next = finish_go || (out_valid_reg && !rsp.ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            evict_reg      <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;

            if (issue)
            begin
                if (idx_reg == LAST_IDX)
                begin
                    issue_done_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (accept)
            begin
                idx_reg        <= '0;
                issue_done_reg <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                evict_reg      <= 1'b0;
            end

            if (scan_data)
            begin
                if (cur_valid && key_rd == key_reg && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (cur_valid && count_reg == FULL_CNT && rank_rd == OLD_RANK)
                begin
                    evict_reg <= 1'b1;
                end
            end

            if (state_reg == ST_PLACE)
            begin
                idx_reg        <= '0;
                issue_done_reg <= 1'b0;
                evict_reg      <= evict_reg && !hit_reg;
            end

            if (finish_go && !hit_reg && !evict_reg)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (accept)
        begin
            key_reg <= KEY_BITS'(req.tile_key);
        end
        if (scan_data)
        begin
            if (cur_valid && key_rd == key_reg && !hit_reg)
            begin
                hit_idx_reg  <= rd_idx_reg;
                hit_rank_reg <= rank_rd;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (cur_valid && count_reg == FULL_CNT && rank_rd == OLD_RANK)
            begin
                victim_idx_reg <= rd_idx_reg;
                victim_key_reg <= key_rd;
            end
        end
        if (state_reg == ST_PLACE)
        begin
            if (hit_reg)
            begin
                slot_reg <= hit_idx_reg;
            end
            else if (evict_reg && victim_idx_reg < free_idx_reg)
            begin
                slot_reg <= victim_idx_reg;
            end
            else
            begin
                slot_reg <= free_idx_reg;
            end
        end
        if (finish_go)
        begin
            out_hit_reg     <= hit_reg;
            out_slot_reg    <= slot_reg;
            out_evicted_reg <= evict_reg;
            out_evkey_reg   <= evict_reg ? victim_key_reg : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.slot        = ltc_pkg::SLOT_BITS'(out_slot_reg);
    assign rsp.evicted     = out_evicted_reg;
    assign rsp.evicted_key = ltc_pkg::EVKEY_BITS'(out_evkey_reg);

`ifndef ASSERT_OFF
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_reg) == int'(count_reg)))
        else $error("entry count differs from number of valid entries");

    a_slot_free_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && !hit_reg) |->
            (!valid_reg[slot_reg] || (evict_reg && slot_reg == victim_idx_reg)))
        else $error("miss placed into an occupied entry");

    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE && !hit_reg && count_reg == FULL_CNT) |-> evict_reg)
        else $error("full store without an eviction candidate");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented after finish");
`endif

endmodule

// File: dv/lru_tile_cache_test.sv
// ----------------------------------------------------------------------------
// lru_tile_cache_test
// Self-checking bench for the tile key cache. A local mirror of the tag store
// (valid bits, keys, recency ranks) predicts hit, slot and eviction for every
// request transfer; each response transfer is checked against the oldest
// prediction. Directed key extremes, fill and eviction, and recency checks run
// first, then mixed random traffic over key pools of varying size, with bursty
// requests and a stalling response side.
// ----------------------------------------------------------------------------
module lru_tile_cache_test;

    localparam int NUM_ENTRIES = ltc_pkg::CACHE_SIZE;
    localparam int KB          = ltc_pkg::KEY_BITS;
    localparam int TKB         = ltc_pkg::TILE_KEY_BITS;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 2 * NUM_ENTRIES + 10;

    typedef struct packed {
        logic                          hit;
        logic [ltc_pkg::SLOT_BITS-1:0] slot;
        logic                          evicted;
        logic [ltc_pkg::EVKEY_BITS-1:0] evicted_key;
    } lookup_result_t;

    logic clk;
    logic rst_n;

    ltc_req_if req_ch ();
    ltc_rsp_if rsp_ch ();

    lru_tile_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // mirror of the tag store
    bit              mirror_valid [NUM_ENTRIES];
    logic [KB-1:0]   mirror_key   [NUM_ENTRIES];
    int unsigned     mirror_rank  [NUM_ENTRIES];
    int              mirror_count;

    lookup_result_t  pending_lookups [$];

    int error_count;
    int sent_count;
    int checked_count;
    int hit_count;
    int miss_count;
    int evict_count;

    int burst_left;
    int pending_gap;
    bit req_high;

    logic [TKB-1:0] key_pool [64];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout: %0d requests sent, %0d responses checked",
                 sent_count, checked_count);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic lookup_result_t predict_lookup(input logic [TKB-1:0] tile_key);
        lookup_result_t res;
        logic [KB-1:0]  key;
        logic [KB-1:0]  ev_key;
        int             found;
        int             free_slot;
        int             oldest;
        int unsigned    best;
        int unsigned    r;
        key       = tile_key[KB-1:0];
        ev_key    = '0;
        found     = -1;
        free_slot = -1;
        oldest    = -1;
        best      = 0;
        res       = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (found < 0 && mirror_valid[i] && mirror_key[i] == key)
                found = i;
        end
        if (found >= 0)
        begin
            r = mirror_rank[found];
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (mirror_valid[i] && mirror_rank[i] < r)
                    mirror_rank[i]++;
            end
            mirror_rank[found] = 0;
            res.hit  = 1'b1;
            res.slot = found[ltc_pkg::SLOT_BITS-1:0];
            hit_count++;
        end
        else
        begin
            if (mirror_count >= NUM_ENTRIES - 1)
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (mirror_valid[i] && (oldest < 0 || mirror_rank[i] > best))
                    begin
                        oldest = i;
                        best   = mirror_rank[i];
                    end
                end
                if (oldest >= 0)
                begin
                    res.evicted          = 1'b1;
                    ev_key               = mirror_key[oldest];
                    mirror_valid[oldest] = 1'b0;
                    mirror_count--;
                    evict_count++;
                end
            end
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (mirror_valid[i])
                    mirror_rank[i]++;
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (free_slot < 0)
                free_slot = 0;
            mirror_valid[free_slot] = 1'b1;
            mirror_key[free_slot]   = key;
            mirror_rank[free_slot]  = 0;
            mirror_count++;
            res.slot = free_slot[ltc_pkg::SLOT_BITS-1:0];
            miss_count++;
        end
        res.evicted_key = ev_key;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // one request transfer; bursts of random length, random gaps between them
    task automatic send_key(input logic [TKB-1:0] key);
        repeat (pending_gap) @(posedge clk);
        pending_gap = 0;
        req_ch.valid    <= 1'b1;
        req_ch.tile_key <= key;
        req_high = 1'b1;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        pending_lookups.push_back(predict_lookup(key));
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                pending_gap = $urandom_range(1, 45);
                req_ch.valid <= 1'b0;
                req_high = 1'b0;
            end
        end
    endtask

    task automatic idle_requests();
        if (req_high)
        begin
            req_ch.valid <= 1'b0;
            req_high = 1'b0;
        end
        if (pending_gap == 0)
            pending_gap = 1;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        idle_requests();
        while (pending_lookups.size() != 0) @(posedge clk);
    endtask

    // response side stalls on its own pattern of phases
    initial
    begin
        int stall_left;
        int phase_left;
        int stall_mode;
        stall_left = 0;
        phase_left = 0;
        stall_mode = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                phase_left = $urandom_range(200, 800);
            end
            phase_left--;
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (stall_mode == 1 && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 8);
                else if (stall_mode == 2 && $urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(5, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch($sformatf("response with no request outstanding: hit=%0b slot=%0d",
                                          rsp_ch.hit, rsp_ch.slot));
            else
            begin
                want = pending_lookups.pop_front();
                checked_count++;
                if (rsp_ch.hit !== want.hit)
                    report_mismatch($sformatf("#%0d hit got %b want %b",
                                              checked_count, rsp_ch.hit, want.hit));
                if (rsp_ch.slot !== want.slot)
                    report_mismatch($sformatf("#%0d slot got %0d want %0d",
                                              checked_count, rsp_ch.slot, want.slot));
                if (rsp_ch.evicted !== want.evicted)
                    report_mismatch($sformatf("#%0d evicted got %b want %b",
                                              checked_count, rsp_ch.evicted, want.evicted));
                if (rsp_ch.evicted_key !== want.evicted_key)
                    report_mismatch($sformatf("#%0d evicted_key got %h want %h",
                                              checked_count, rsp_ch.evicted_key,
                                              want.evicted_key));
            end
        end
    end

    task automatic test_key_extremes();
        send_key('0);
        send_key('1);
        send_key('0);
        send_key('1);
        send_key(32'h8000_0000);
        send_key(32'h0000_0001);
        send_key(32'haaaa_aaaa);
        send_key(32'h5555_5555);
        wait_drained();
    endtask

    task automatic test_fill_and_evict();
        // fill up to the eviction threshold, then push past it
        int next;
        next = 0;
        while (mirror_count < NUM_ENTRIES - 1)
        begin
            send_key(32'h1000_0000 + next);
            next++;
        end
        send_key(32'h2000_0001);
        send_key(32'h2000_0002);
        wait_drained();
    endtask

    task automatic test_recency_order();
        logic [KB-1:0] oldest_key;
        logic [KB-1:0] newest_key;
        int unsigned   best;
        best = 0;
        oldest_key = '0;
        newest_key = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (mirror_valid[i] && mirror_rank[i] >= best)
            begin
                best       = mirror_rank[i];
                oldest_key = mirror_key[i];
            end
            if (mirror_valid[i] && mirror_rank[i] == 0)
                newest_key = mirror_key[i];
        end
        // hit on the least recent entry saves it from the next eviction
        send_key(oldest_key);
        send_key(newest_key);
        send_key(newest_key);
        send_key(32'h3000_0000);
        send_key(oldest_key);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int num_items);
        int             seg_left;
        int             pool_size;
        int             pick;
        logic [TKB-1:0] key;
        seg_left  = 0;
        pool_size = 16;
        for (int i = 0; i < 64; i++)
            key_pool[i] = $urandom;
        for (int n = 0; n < num_items; n++)
        begin
            if (seg_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pool_size = $urandom_range(4, 12);
                    1: pool_size = $urandom_range(14, 20);
                    2: pool_size = $urandom_range(24, 64);
                    default: pool_size = 16;
                endcase
                seg_left = $urandom_range(50, 150);
                if ($urandom_range(0, 2) == 0)
                    key_pool[$urandom_range(0, 63)] = $urandom;
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                key = $urandom;
            else if (pick < 15)
                key = key_pool[$urandom_range(0, pool_size - 1)] ^ (32'h1 << $urandom_range(0, 31));
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_key(key);
        end
        wait_drained();
    endtask

    initial
    begin
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        hit_count     = 0;
        miss_count    = 0;
        evict_count   = 0;
        burst_left    = 0;
        pending_gap   = 0;
        req_high      = 1'b0;
        mirror_count  = 0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            mirror_valid[i] = 1'b0;
            mirror_key[i]   = '0;
            mirror_rank[i]  = 0;
        end
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.tile_key = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_extremes();
        test_fill_and_evict();
        test_recency_order();
        test_random_traffic(1150);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (pending_lookups.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", pending_lookups.size()));

        $display("covered %0d lookups: %0d hits, %0d misses, %0d evictions",
                 sent_count, hit_count, miss_count, evict_count);
        $display("bursty requests against a stalling response side, %0d responses checked",
                 checked_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
